### sv/qat_pkg.sv
// Shared types and constants for the quoted argument tokenizer.
// Depends on nothing; every other file takes names from here by scope.
`default_nettype none

package qat_pkg;

   localparam logic [7:0] QUOTE_CH  = 8'h22;
   localparam logic [7:0] BSLASH_CH = 8'h5C;
   localparam logic [7:0] SPACE_CH  = 8'h20;
   localparam logic [7:0] TAB_CH    = 8'h09;
   localparam logic [7:0] CR_CH     = 8'h0D;

   typedef enum logic {
      ACTION_CHAR = 1'b0,
      ACTION_EOL  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_QUOTE_END = 2'd1,
      STATUS_NO_SPACE  = 2'd2,
      STATUS_UNCLOSED  = 2'd3
   } status_type;

   typedef struct packed {
      logic       in_word;
      logic       in_quotes;
      logic       escape_pending;
      logic       after_closing_quote;
      logic       bare_word_quote_end;
      status_type error_code;
   } flags_type;

   typedef struct packed {
      action_type action;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic       emit_valid;
      logic [7:0] emit_char;
      logic       token_done;
      logic       line_done;
      status_type status;
   } rsp_type;

endpackage

`default_nettype wire

### sv/qat_req_if.sv
// Input channel of the tokenizer: valid/ready handshake with a request payload.
// Depends on qat_pkg.
`default_nettype none

interface qat_req_if;
   logic              valid;
   logic              ready;
   qat_pkg::req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/qat_rsp_if.sv
// Result channel of the tokenizer: valid/ready handshake with a result payload.
// Depends on qat_pkg.
`default_nettype none

interface qat_rsp_if;
   logic              valid;
   logic              ready;
   qat_pkg::rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/qat_step.sv
// Per-character tokenizer step: next flags and the result for one transaction.
// Purely combinational; depends on qat_pkg.
`default_nettype none

module qat_step (
   input  qat_pkg::flags_type flags_cur,
   input  qat_pkg::req_type   item,
   output qat_pkg::flags_type flags_next,
   output qat_pkg::rsp_type   result
);

   logic white;
   logic is_quote;
   logic is_bslash;

   assign white     = (item.ch == qat_pkg::SPACE_CH) ||
                      ((item.ch >= qat_pkg::TAB_CH) && (item.ch <= qat_pkg::CR_CH));
   assign is_quote  = (item.ch == qat_pkg::QUOTE_CH);
   assign is_bslash = (item.ch == qat_pkg::BSLASH_CH);

   always_comb begin
      flags_next        = flags_cur;
      result.emit_valid = 1'b0;
      result.emit_char  = 8'h00;
      result.token_done = 1'b0;
      result.line_done  = 1'b0;
      result.status     = qat_pkg::STATUS_OK;

      case (item.action)
         qat_pkg::ACTION_EOL: begin
            result.line_done = 1'b1;
            if (flags_cur.error_code != qat_pkg::STATUS_OK) begin
               result.status = flags_cur.error_code;
            end else if (flags_cur.in_quotes) begin
               result.status = qat_pkg::STATUS_UNCLOSED;
            end else if (flags_cur.bare_word_quote_end) begin
               result.status = qat_pkg::STATUS_QUOTE_END;
            end else begin
               result.token_done = flags_cur.in_word;
            end
            flags_next = '0;
         end
         qat_pkg::ACTION_CHAR: begin
            if (flags_cur.error_code != qat_pkg::STATUS_OK) begin
               // drop until end of line
            end else if (flags_cur.in_word && flags_cur.in_quotes) begin
               if (flags_cur.escape_pending) begin
                  flags_next.escape_pending = 1'b0;
                  if (is_quote || is_bslash) begin
                     result.emit_valid = 1'b1;
                     result.emit_char  = item.ch;
                  end
               end else if (is_quote) begin
                  flags_next.in_quotes           = 1'b0;
                  flags_next.in_word             = 1'b0;
                  flags_next.after_closing_quote = 1'b1;
                  result.token_done              = 1'b1;
               end else if (is_bslash) begin
                  flags_next.escape_pending = 1'b1;
               end else begin
                  result.emit_valid = 1'b1;
                  result.emit_char  = item.ch;
               end
            end else if (flags_cur.in_word && is_quote) begin
               result.emit_valid              = 1'b1;
               result.emit_char               = item.ch;
               flags_next.bare_word_quote_end = 1'b1;
            end else if (flags_cur.in_word && !white) begin
               result.emit_valid              = 1'b1;
               result.emit_char               = item.ch;
               flags_next.bare_word_quote_end = 1'b0;
            end else if (flags_cur.bare_word_quote_end) begin
               flags_next.error_code = qat_pkg::STATUS_QUOTE_END;
            end else if (flags_cur.in_word) begin
               flags_next.in_word = 1'b0;
               result.token_done  = 1'b1;
            end else if (flags_cur.after_closing_quote && !white) begin
               flags_next.error_code = qat_pkg::STATUS_NO_SPACE;
            end else if (is_quote) begin
               flags_next.in_word             = 1'b1;
               flags_next.in_quotes           = 1'b1;
               flags_next.after_closing_quote = 1'b0;
            end else if (!white) begin
               flags_next.in_word             = 1'b1;
               flags_next.in_quotes           = 1'b0;
               flags_next.after_closing_quote = 1'b0;
               result.emit_valid              = 1'b1;
               result.emit_char               = item.ch;
            end else begin
               flags_next.after_closing_quote = 1'b0;
            end
            result.status = flags_next.error_code;
         end
         default: begin
            flags_next = flags_cur;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/quoted_argument_tokenizer_top.sv
// Quoted argument tokenizer top: input register, step logic, result register.
// An item waits in the input register until the result register is free.
// Throughput: one transaction per cycle unless the result channel stalls.
// Reset (synchronous, active high) clears all token flags and both valid bits.
// Depends on qat_pkg, qat_req_if, qat_rsp_if and qat_step.
`default_nettype none

module quoted_argument_tokenizer_top (
   input  logic clock,
   input  logic reset,
   qat_req_if.sink   req_chan,
   qat_rsp_if.source rsp_chan
);

   logic               in_valid_ff;
   logic               in_valid_in;
   qat_pkg::req_type   in_item_ff;
   qat_pkg::req_type   in_item_in;
   qat_pkg::flags_type flags_ff;
   qat_pkg::flags_type flags_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   qat_pkg::rsp_type   out_rsp_ff;
   qat_pkg::rsp_type   out_rsp_in;

   qat_pkg::flags_type step_flags;
   qat_pkg::rsp_type   step_rsp;

   logic out_free;
   logic advance;
   logic accept;

   qat_step u_step (
      .flags_cur  (flags_ff),
      .item       (in_item_ff),
      .flags_next (step_flags),
      .result     (step_rsp)
   );

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_rsp_ff;

   always_comb begin
      in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_item_in   = accept ? req_chan.payload : in_item_ff;
      flags_in     = advance ? step_flags : flags_ff;
      out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
      out_rsp_in   = advance ? step_rsp : out_rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         flags_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         flags_ff     <= flags_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_rsp_ff <= out_rsp_in;
   end

endmodule

`default_nettype wire
